// ===== src/lz10_pkg.sv =====
// lz10 decompressor shared types and constants
`timescale 1ns / 1ps
`default_nettype none
package lz10_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } lz10_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       bad_distance;
  } lz10_out_t;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_LIT   = 2'd1;
  localparam logic [1:0] CMD_REF   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lit_byte;
    logic [12:0] distance;
    logic [4:0]  count;
    logic        stream_end;
  } lz10_cmd_t;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

endpackage
`default_nettype wire

// ===== src/lz10_parser.sv =====
// front end: header, flag and reference parsing into copy commands
`timescale 1ns / 1ps
`default_nettype none
module lz10_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  lz10_pkg::lz10_in_t     in_word,
  output logic                   cmd_push,
  output lz10_pkg::lz10_cmd_t    cmd,
  input  wire logic              cmd_full
);
  import lz10_pkg::*;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_HEADER   = 3'd1;
  localparam logic [2:0] PH_FLAG     = 3'd2;
  localparam logic [2:0] PH_LITERAL  = 3'd3;
  localparam logic [2:0] PH_REF_HIGH = 3'd4;
  localparam logic [2:0] PH_REF_LOW  = 3'd5;
  localparam logic [2:0] PH_DONE     = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [23:0] total_length, total_length_next;
  logic [23:0] issued, issued_next;
  logic [7:0]  flag_bits, flag_bits_next;
  logic [3:0]  flags_left, flags_left_next;
  logic [7:0]  reference_high, reference_high_next;

  logic        accept;
  logic [7:0]  b;
  logic [7:0]  shifted;
  logic [3:0]  left_dec;
  logic [2:0]  item_next_phase;
  logic [4:0]  ref_len;
  logic [23:0] remain;
  logic [23:0] issued_inc;

  assign full     = cmd_full;
  assign accept   = push & ~cmd_full;
  assign b        = in_word.data_byte;
  assign shifted  = {flag_bits[6:0], 1'b0};
  assign left_dec = flags_left - 4'd1;
  assign item_next_phase = (left_dec == 4'd0) ? PH_FLAG :
                           (shifted[7] ? PH_REF_HIGH : PH_LITERAL);
  assign ref_len    = {1'b0, reference_high[7:4]} + 5'd3;
  assign remain     = total_length - issued;
  assign issued_inc = issued + 24'd1;

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    total_length_next   = total_length;
    issued_next         = issued;
    flag_bits_next      = flag_bits;
    flags_left_next     = flags_left;
    reference_high_next = reference_high;
    cmd_push            = 1'b0;
    cmd.kind            = CMD_START;
    cmd.lit_byte        = b;
    cmd.distance        = {1'b0, reference_high[3:0], b} + 13'd1;
    cmd.count           = 5'd1;
    cmd.stream_end      = 1'b0;
    if (accept) begin
      if (in_word.start_req) begin
        phase_next          = PH_HEADER;
        header_index_next   = 2'd1;
        total_length_next   = '0;
        issued_next         = '0;
        flag_bits_next      = '0;
        flags_left_next     = '0;
        reference_high_next = '0;
        cmd_push            = 1'b1;
        cmd.kind            = CMD_START;
      end else begin
        case (phase)
          PH_HEADER: begin
            case (header_index)
              2'd1: begin
                total_length_next[7:0] = total_length[7:0] | b;
                header_index_next = 2'd2;
              end
              2'd2: begin
                total_length_next[15:8] = total_length[15:8] | b;
                header_index_next = 2'd3;
              end
              2'd3: begin
                total_length_next[23:16] = total_length[23:16] | b;
                header_index_next = 2'd0;
                phase_next = ({total_length[23:16] | b, total_length[15:0]} == 24'd0)
                             ? PH_DONE : PH_FLAG;
              end
              default: begin
                header_index_next = 2'd1;
              end
            endcase
          end
          PH_FLAG: begin
            flag_bits_next  = b;
            flags_left_next = 4'd8;
            phase_next      = b[7] ? PH_REF_HIGH : PH_LITERAL;
          end
          PH_LITERAL: begin
            cmd_push       = 1'b1;
            cmd.kind       = CMD_LIT;
            cmd.count      = 5'd1;
            cmd.stream_end = (issued_inc == total_length);
            issued_next    = issued_inc;
            if (issued_inc == total_length) begin
              phase_next = PH_DONE;
            end else begin
              flag_bits_next  = shifted;
              flags_left_next = left_dec;
              phase_next      = item_next_phase;
            end
          end
          PH_REF_HIGH: begin
            reference_high_next = b;
            phase_next          = PH_REF_LOW;
          end
          PH_REF_LOW: begin
            cmd_push = 1'b1;
            cmd.kind = CMD_REF;
            if ({19'd0, ref_len} < remain) begin
              // whole reference fits before the end of the stream
              cmd.count       = ref_len;
              issued_next     = issued + {19'd0, ref_len};
              flag_bits_next  = shifted;
              flags_left_next = left_dec;
              phase_next      = item_next_phase;
            end else begin
              cmd.count      = remain[4:0];
              cmd.stream_end = 1'b1;
              issued_next    = total_length;
              phase_next     = PH_DONE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      header_index   <= '0;
      total_length   <= '0;
      issued         <= '0;
      flag_bits      <= '0;
      flags_left     <= '0;
      reference_high <= '0;
    end else begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      total_length   <= total_length_next;
      issued         <= issued_next;
      flag_bits      <= flag_bits_next;
      flags_left     <= flags_left_next;
      reference_high <= reference_high_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/lz10_cmd_fifo.sv =====
// short command queue between parser and copy unit
`timescale 1ns / 1ps
`default_nettype none
module lz10_cmd_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  lz10_pkg::lz10_cmd_t    wr_data,
  output logic                   is_full,
  input  wire logic              rd_en,
  output lz10_pkg::lz10_cmd_t    rd_data,
  output logic                   is_empty
);
  import lz10_pkg::*;

  lz10_cmd_t          slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_AW:0]   fill;
  logic               do_wr, do_rd;

  assign is_full  = (fill == (CMDQ_AW + 1)'(CMDQ_DEPTH));
  assign is_empty = (fill == '0);
  assign do_wr    = wr_en & ~is_full;
  assign do_rd    = rd_en & ~is_empty;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/lz10_copier.sv =====
// back end: history memory, byte copy and output register
`timescale 1ns / 1ps
`default_nettype none
module lz10_copier #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_empty,
  input  lz10_pkg::lz10_cmd_t    cmd,
  output logic                   cmd_pop,
  output logic                   out_valid,
  output lz10_pkg::lz10_out_t    out_word,
  input  wire logic              out_pop
);
  import lz10_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);

  localparam logic [1:0] S_FETCH = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic [7:0]    history [HISTORY_DEPTH];
  logic [1:0]    state;
  lz10_cmd_t     cur;
  logic [AW-1:0] wr_ptr;
  logic [12:0]   seen;      // bytes written in this stream, saturating at 4096
  logic [7:0]    rd_data;
  logic [AW:0]   diff;
  logic [AW:0]   diff_wrap;
  logic [AW-1:0] rd_addr;
  logic          emit;
  logic          is_bad;
  logic          is_lit;
  logic [7:0]    byte_val;

  assign cmd_pop   = (state == S_FETCH) & ~cmd_empty;
  assign diff      = {1'b0, wr_ptr} - (AW + 1)'(cur.distance);
  assign diff_wrap = diff + (AW + 1)'(HISTORY_DEPTH);
  assign rd_addr   = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];
  assign emit      = (state == S_EMIT) & (~out_valid | out_pop);
  assign is_lit    = (cur.kind == CMD_LIT);
  assign is_bad    = ~is_lit & (cur.distance > seen);
  assign byte_val  = is_lit ? cur.lit_byte : (is_bad ? 8'd0 : rd_data);

  always_ff @(posedge clk) begin
    if (emit) begin
      history[wr_ptr] <= byte_val;
    end
    if (state == S_READ) begin
      rd_data <= history[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.out_byte     <= byte_val;
      out_word.last         <= cur.stream_end & (cur.count == 5'd1);
      out_word.bad_distance <= is_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FETCH;
      cur       <= '0;
      wr_ptr    <= '0;
      seen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_FETCH: begin
          if (!cmd_empty) begin
            if (cmd.kind == CMD_START) begin
              wr_ptr <= '0;
              seen   <= '0;
            end else begin
              cur   <= cmd;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            wr_ptr    <= (wr_ptr == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
            if (seen != 13'd4096) begin
              seen <= seen + 13'd1;
            end
            cur.count <= cur.count - 5'd1;
            state     <= (cur.count == 5'd1) ? S_FETCH : S_READ;
          end
        end
        default: begin
          state <= S_FETCH;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/lz10_decompressor.sv =====
// lz10 decompressor top level: parser, command queue and copy unit
//
//   channel   handshake         word       contents
//   input     push / full       in_word    data_byte, start_req
//   output    pop / empty       out_word   out_byte, last, bad_distance
//
// an input word is taken whenever the command queue has room
// in the copy unit each command is taken in the fetch state, then each of its bytes
// passes the read state (history read) and the emit state (emit and history write)
// reset clears all control state; the history memory needs no clearing pass
// a stalled output holds the copy unit; the parser runs on until the queue fills
`timescale 1ns / 1ps
`default_nettype none
module lz10_decompressor #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  output logic                 full,
  input  lz10_pkg::lz10_in_t   in_word,
  output logic                 empty,
  input  wire logic            pop,
  output lz10_pkg::lz10_out_t  out_word
);
  import lz10_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  lz10_cmd_t q_in, q_out;
  logic      out_valid;

  assign empty = ~out_valid;

  lz10_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .cmd_push (q_push),
    .cmd      (q_in),
    .cmd_full (q_full)
  );

  lz10_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_data  (q_in),
    .is_full  (q_full),
    .rd_en    (q_pop),
    .rd_data  (q_out),
    .is_empty (q_empty)
  );

  lz10_copier #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_copier (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd       (q_out),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_pop   (pop)
  );

  // a flagged reference byte always reads as zero
  a_bad_is_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_word.bad_distance) |-> (out_word.out_byte == 8'd0))
    else $error("bad distance byte not zero");

  // queue writes only happen with room
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // nothing waits on the output right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("output not empty after reset");

  // a start word reaches the queue as a start command
  a_start_cmd: assert property (@(posedge clk) disable iff (rst)
    (push && !full && in_word.start_req) |-> (q_push && q_in.kind == CMD_START))
    else $error("start word not forwarded");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the lz10 decompressor with a behavioral predictor
`timescale 1ns / 1ps
module testbench;
  import lz10_pkg::*;

  localparam int HIST_DEPTH = 4096;
  localparam int TOTAL_WORDS = 130;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_FLAG, PH_LITERAL, PH_REF_HIGH, PH_REF_LOW, PH_DONE
  } parse_phase_t;

  class lz10_scoreboard;
    parse_phase_t phase;
    logic [1:0]  hdr_idx;
    logic [23:0] total_len;
    logic [23:0] written;
    logic [7:0]  flags;
    logic [3:0]  flags_left;
    logic [7:0]  ref_high;
    logic [7:0]  hist [HIST_DEPTH];
    lz10_out_t   pending_bytes [$];
    int          errors;

    function new();
      errors = 0;
      phase = PH_IDLE;
      hdr_idx = '0;
      total_len = '0;
      written = '0;
      flags = '0;
      flags_left = '0;
      ref_high = '0;
      foreach (hist[i]) hist[i] = 8'h00;
    endfunction

    function void store_byte(logic [7:0] b, logic bad);
      lz10_out_t w;
      hist[written % HIST_DEPTH] = b;
      written = written + 24'd1;
      w.out_byte = b;
      w.last = (written == total_len);
      w.bad_distance = bad;
      pending_bytes.push_back(w);
    endfunction

    function void pick_item();
      phase = flags[7] ? PH_REF_HIGH : PH_LITERAL;
    endfunction

    function void next_item();
      flags = flags << 1;
      flags_left = flags_left - 4'd1;
      if (flags_left == 4'd0) begin
        phase = PH_FLAG;
      end else begin
        pick_item();
      end
    endfunction

    // advance the parser by one accepted input word
    function void take_byte(logic [7:0] b, logic start);
      int copy_len;
      int distance;
      bit finished;
      if (start) begin
        phase = PH_HEADER;
        hdr_idx = 2'd1;
        total_len = '0;
        written = '0;
        flags = '0;
        flags_left = '0;
        ref_high = '0;
        return;
      end
      case (phase)
        PH_HEADER: begin
          total_len[8 * (int'(hdr_idx) - 1) +: 8] = b;
          if (hdr_idx >= 2'd3) begin
            hdr_idx = 2'd0;
            phase = (total_len == 24'd0) ? PH_DONE : PH_FLAG;
          end else begin
            hdr_idx = hdr_idx + 2'd1;
          end
        end
        PH_FLAG: begin
          flags = b;
          flags_left = 4'd8;
          pick_item();
        end
        PH_LITERAL: begin
          store_byte(b, 1'b0);
          if (written == total_len) begin
            phase = PH_DONE;
          end else begin
            next_item();
          end
        end
        PH_REF_HIGH: begin
          ref_high = b;
          phase = PH_REF_LOW;
        end
        PH_REF_LOW: begin
          copy_len = int'(ref_high[7:4]) + 3;
          distance = int'({ref_high[3:0], b}) + 1;
          finished = 1'b0;
          for (int j = 0; j < copy_len; j++) begin
            // a reach before the start of the stream yields a flagged zero
            if (distance > int'(written)) begin
              store_byte(8'h00, 1'b1);
            end else begin
              store_byte(hist[(int'(written) - distance) % HIST_DEPTH], 1'b0);
            end
            if (written == total_len) begin
              finished = 1'b1;
              break;
            end
          end
          if (finished) begin
            phase = PH_DONE;
          end else begin
            next_item();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_output(lz10_out_t got);
      lz10_out_t exp;
      if (pending_bytes.size() == 0) begin
        $error("unexpected output word: out_byte %02h last %0b bad_distance %0b",
               got.out_byte, got.last, got.bad_distance);
        errors++;
        return;
      end
      exp = pending_bytes.pop_front();
      if (got.out_byte !== exp.out_byte) begin
        $error("out_byte: expected %02h, got %02h", exp.out_byte, got.out_byte);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        errors++;
      end
      if (got.bad_distance !== exp.bad_distance) begin
        $error("bad_distance: expected %0b, got %0b", exp.bad_distance, got.bad_distance);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push;
  logic      full;
  lz10_in_t  in_word;
  logic      empty;
  logic      pop;
  lz10_out_t out_word;

  lz10_scoreboard board;
  int  words_accepted;
  bit  in_quiet;
  bit  out_quiet;

  lz10_decompressor DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_word  (in_word),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // push stays high across back-to-back words; it is only lowered for a gap
  task automatic send_word(input logic [7:0] b, input logic start);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_word <= '{data_byte: b, start_req: start};
    do @(posedge clk); while (full);
    board.take_byte(b, start);
    words_accepted++;
  endtask

  task automatic send_header(input logic [7:0] kind_byte, input logic [23:0] len);
    send_word(kind_byte, 1'b1);
    send_word(len[7:0], 1'b0);
    send_word(len[15:8], 1'b0);
    send_word(len[23:16], 1'b0);
  endtask

  // well-formed stream with random content; some are cut short, some get trailing noise
  task automatic send_random_stream(input int out_len, input bit max_copies);
    int made;
    int stop_at;
    int distance;
    logic [7:0] flag;
    logic [7:0] hi;
    made = 0;
    stop_at = out_len;
    in_quiet = ($urandom_range(0, 3) == 0);
    if (!max_copies && $urandom_range(0, 7) == 0) stop_at = $urandom_range(0, out_len - 1);
    send_header(8'($urandom()), 24'(out_len));
    while (made < stop_at) begin
      flag = max_copies ? 8'hFF : 8'($urandom());
      send_word(flag, 1'b0);
      for (int i = 7; i >= 0 && made < stop_at; i--) begin
        if (!flag[i]) begin
          send_word(8'($urandom()), 1'b0);
          made++;
        end else begin
          hi[7:4] = max_copies ? 4'hF : 4'($urandom_range(0, 15));
          if (made > 0 && $urandom_range(0, 7) != 0) begin
            distance = $urandom_range(1, (made < HIST_DEPTH) ? made : HIST_DEPTH);
          end else begin
            distance = $urandom_range(1, HIST_DEPTH);
          end
          hi[3:0] = 4'((distance - 1) >> 8);
          send_word(hi, 1'b0);
          send_word(8'((distance - 1) & 255), 1'b0);
          made += int'(hi[7:4]) + 3;
        end
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(8'($urandom()), 1'b0);
    end
  endtask

  initial begin
    push = 1'b0;
    pop = 1'b0;
    in_word = '0;
    words_accepted = 0;
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_word(8'h55, 1'b0);              // idle: dropped before any start
    send_header(8'h10, 24'd4);
    send_word(8'h40, 1'b0);              // literal, then a reference
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);              // three copies at distance one
    send_word(8'h00, 1'b0);
    send_word(8'h3C, 1'b0);              // stream finished: dropped
    send_header(8'h00, 24'd0);           // zero length
    send_word(8'hAA, 1'b0);
    send_header(8'hFF, 24'd4);           // longest reach on empty history, ends mid-copy
    send_word(8'h80, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_header(8'h10, 24'hFFFFFF);
    send_word(8'h00, 1'b0);
    send_word(8'hA5, 1'b0);
    send_header(8'hFF, 24'd2);           // restart in the middle of a stream
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);

    // one stream made only of the longest copies
    send_random_stream(200, 1'b1);

    while (words_accepted < TOTAL_WORDS) begin
      send_random_stream(($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                     : $urandom_range(9, 80), 1'b0);
    end
    push <= 1'b0;

    while (board.pending_bytes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) begin
      $display("lz10_decompressor regression: pass");
    end else begin
      $display("lz10_decompressor regression: fail");
    end
    $finish;
  end

  initial begin
    int stall;
    int n;
    n = 0;
    @(negedge rst);
    forever begin
      if (n % 40 == 0) out_quiet = ($urandom_range(0, 3) == 0);
      stall = out_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      board.check_output(out_word);
      n++;
    end
  end

  initial begin
    #5_000_000;
    $display("lz10_decompressor regression: fail");
    $finish;
  end

endmodule
